### sv/polar_gaussian_sampler_assert.svh
// ----------------------------------------------------------------------------
// Polar Gaussian sampler assertion macros
// Concurrent checks; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POLAR_GAUSSIAN_SAMPLER_ASSERT_SVH
`define POLAR_GAUSSIAN_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define PGS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pgs check failed");
`define PGS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pgs check failed");
`else
`define PGS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PGS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### sv/pgs_pkg.sv
// ----------------------------------------------------------------------------
// Polar Gaussian sampler package
// Fixed-point constants shared by the sampler.
// ----------------------------------------------------------------------------
`default_nettype none
package pgs_pkg;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int WN_BITS         = 62;   // normalized w, in [2^60, 2^62)
   localparam int Q30             = 30;
   localparam int Q_BITS          = 31;
   localparam int OUT_BITS        = 16;
   localparam int RND_SHIFT       = 33;   // Q.45 -> Q.12
   localparam logic [Q_BITS-1:0] TWO_LN2_Q30 = 31'd1488522236;
   localparam logic [OUT_BITS:0] OUT_POS_MAX = 17'd32767;
   localparam logic [OUT_BITS:0] OUT_NEG_MAX = 17'd32768;
endpackage
`default_nettype wire

### sv/polar_gaussian_sampler.sv
// ----------------------------------------------------------------------------
// Polar Gaussian sampler
// Marsaglia polar transform: uniform pairs in, Q3.12 normal deviate pairs out.
// ----------------------------------------------------------------------------
//  channel | ports                                  | dir
//  req     | req_valid/ready, uniform_first/second  | in
//  rsp     | rsp_valid/ready, normal_value, last    | out
//
//  Pair path: p1-p4, b steps, c, m, d steps, g, out; rejected pairs give none.
//  Two deviates per pair on a one-word channel.
//  The whole pipeline holds while the output word is not taken or while the
//  first deviate of a pair is being shown.
//  Synchronous active-high reset clears only the valid bits and the last flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polar_gaussian_sampler_assert.svh"
module polar_gaussian_sampler #(
   parameter int SAMPLE_BITS = pgs_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_BITS-1:0]        req_uniform_first,
   input  logic signed [SAMPLE_BITS-1:0]        req_uniform_second,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pgs_pkg::OUT_BITS-1:0]  rsp_normal_value,
   output logic                                 rsp_last_of_pair
);
   localparam int SB        = SAMPLE_BITS;
   localparam int TWOF      = 2 * (SB - 1);
   localparam int W_BITS    = 2 * SB;
   localparam int WN        = pgs_pkg::WN_BITS;
   localparam int Q30       = pgs_pkg::Q30;
   localparam int QB        = pgs_pkg::Q_BITS;
   localparam int OB        = pgs_pkg::OUT_BITS;
   localparam int RS        = pgs_pkg::RND_SHIFT;
   localparam int SQ_STEPS  = WN / 2;
   localparam int LOG_STEPS = Q30;
   localparam int E_BITS    = $clog2(WN / 2);
   localparam int N_BITS    = $clog2(TWOF + 1);
   localparam int LQ_BITS   = N_BITS + Q30;
   localparam int MH_BITS   = N_BITS + QB;
   localparam int ML_BITS   = Q30 + QB;
   localparam int V_BITS    = N_BITS + QB + 1;
   localparam int T_STEPS   = (V_BITS + 1) / 2;
   localparam int VX        = 2 * T_STEPS;
   localparam int ND_BITS   = SB + WN / 2 - 1 + Q30;
   localparam int P_BITS    = QB + T_STEPS;
   localparam int R_BITS    = P_BITS + 1 - RS;
   localparam logic [P_BITS:0] RND = (P_BITS + 1)'(1) << (RS - 1);

   typedef struct packed {
      logic [1:0][SB-1:0] mag;
      logic [1:0]         neg;
   } p1_type;
   typedef struct packed {
      logic [1:0][W_BITS-1:0] sq;
      logic [1:0][SB-1:0]     mag;
      logic [1:0]             neg;
   } p2_type;
   typedef struct packed {
      logic [WN-1:0]      w;
      logic [1:0][SB-1:0] mag;
      logic [1:0]         neg;
   } p3_type;
   typedef struct packed {
      logic [WN-1:0]      w;
      logic [E_BITS-1:0]  e;
      logic [1:0][SB-1:0] mag;
      logic [1:0]         neg;
   } p4_type;
   typedef struct packed {
      logic [WN-1:0]      v;
      logic [WN-1:0]      res;
      logic [QB-1:0]      x;
      logic [Q30-1:0]     f;
      logic [E_BITS-1:0]  e;
      logic [N_BITS-1:0]  n;
      logic [1:0][SB-1:0] mag;
      logic [1:0]         neg;
   } b_type;
   typedef struct packed {
      logic [N_BITS-1:0]  hi;
      logic [Q30-1:0]     lo;
      logic [QB-1:0]      s;
      logic [1:0][QB-1:0] rem;
      logic [1:0][QB-1:0] low;
      logic [1:0]         neg;
   } c_type;
   typedef struct packed {
      logic [MH_BITS-1:0] mh;
      logic [ML_BITS-1:0] ml;
      logic [QB-1:0]      s;
      logic [1:0][QB-1:0] rem;
      logic [1:0][QB-1:0] low;
      logic [1:0]         neg;
   } m_type;
   typedef struct packed {
      logic [QB-1:0]      s;
      logic [1:0][QB-1:0] rem;
      logic [1:0][QB-1:0] low;
      logic [1:0][QB-1:0] q;
      logic [VX-1:0]      tv;
      logic [VX-1:0]      tr;
      logic [1:0]         neg;
   } d_type;
   typedef struct packed {
      logic [1:0][P_BITS-1:0] prod;
      logic [1:0]             neg;
   } g_type;

   // index of the first nonzero bit pair from the top
   function automatic logic [E_BITS-1:0] find_e(logic [WN-1:0] w);
      logic [E_BITS-1:0] e;
      e = '0;
      for (int j = WN / 2 - 1; j >= 0; j--) begin
         if (w[WN-1-2*j -: 2] != 2'b00) begin
            e = E_BITS'(j);
         end
      end
      return e;
   endfunction

   // one root bit of s and, in the first LOG_STEPS steps, one fraction bit of log2
   function automatic b_type b_step(b_type cur, int k);
      b_type               nx;
      logic [WN-1:0]       bitv;
      logic [WN-1:0]       trial;
      logic [2*QB-1:0]     sqx;
      logic [QB:0]         y;
      nx    = cur;
      bitv  = WN'(1) << (2 * (SQ_STEPS - 1 - k));
      trial = cur.res + bitv;
      if (cur.v >= trial) begin
         nx.v   = cur.v - trial;
         nx.res = (cur.res >> 1) + bitv;
      end else begin
         nx.res = cur.res >> 1;
      end
      if (k < LOG_STEPS) begin
         sqx = (2*QB)'(cur.x) * (2*QB)'(cur.x);
         y   = sqx[2*QB-1:Q30];
         if (y[QB]) begin
            nx.x = y[QB:1];
            nx.f = {cur.f[Q30-2:0], 1'b1};
         end else begin
            nx.x = y[QB-1:0];
            nx.f = {cur.f[Q30-2:0], 1'b0};
         end
      end
      return nx;
   endfunction

   // one quotient bit per lane and, in the first T_STEPS steps, one root bit of t
   function automatic d_type d_step(d_type cur, int k);
      d_type         nx;
      logic [QB:0]   r2;
      logic          qb;
      logic [VX-1:0] bitv;
      logic [VX-1:0] trial;
      nx = cur;
      for (int i = 0; i < 2; i++) begin
         r2 = {cur.rem[i], cur.low[i][QB-1]};
         qb = (r2 >= {1'b0, cur.s});
         if (qb) begin
            r2 = r2 - {1'b0, cur.s};
         end
         nx.rem[i] = r2[QB-1:0];
         nx.low[i] = cur.low[i] << 1;
         nx.q[i]   = {cur.q[i][QB-2:0], qb};
      end
      if (k < T_STEPS) begin
         bitv  = VX'(1) << (2 * (T_STEPS - 1 - k));
         trial = cur.tr + bitv;
         if (cur.tv >= trial) begin
            nx.tv = cur.tv - trial;
            nx.tr = (cur.tr >> 1) + bitv;
         end else begin
            nx.tr = cur.tr >> 1;
         end
      end
      return nx;
   endfunction

   logic   adv;
   p1_type p1_ff, p1_in;
   p2_type p2_ff, p2_in;
   p3_type p3_ff, p3_in;
   p4_type p4_ff, p4_in;
   b_type  b_ff [0:SQ_STEPS];
   b_type  b0_in;
   c_type  c_ff, c_in;
   m_type  m_ff, m_in;
   d_type  d_ff [0:QB];
   d_type  d0_in;
   g_type  g_ff, g_in;
   logic [1:0][OB-1:0] out_val_ff, out_val_in;

   logic                p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff;
   logic                p3_ok;
   logic [SQ_STEPS:0]   b_vld_ff;
   logic                c_vld_ff, m_vld_ff, g_vld_ff;
   logic [QB:0]         d_vld_ff;
   logic                out_vld_ff, out_last_ff;

   assign adv       = !out_vld_ff || (rsp_ready && out_last_ff);
   assign req_ready = adv;

   always_comb begin
      logic [W_BITS-1:0]  wsum;
      logic [WN-1:0]      wn;
      logic [LQ_BITS-1:0] lq;
      logic [ND_BITS-1:0] nd;
      logic [P_BITS:0]    rs;
      logic [R_BITS-1:0]  r;
      logic [OB:0]        lim;
      logic [OB:0]        mg;

      p1_in.neg[0] = req_uniform_first[SB-1];
      p1_in.neg[1] = req_uniform_second[SB-1];
      p1_in.mag[0] = p1_in.neg[0] ? SB'(-req_uniform_first) : SB'(req_uniform_first);
      p1_in.mag[1] = p1_in.neg[1] ? SB'(-req_uniform_second) : SB'(req_uniform_second);

      p2_in.mag = p1_ff.mag;
      p2_in.neg = p1_ff.neg;
      for (int i = 0; i < 2; i++) begin
         p2_in.sq[i] = W_BITS'(p1_ff.mag[i]) * W_BITS'(p1_ff.mag[i]);
      end

      wsum      = p2_ff.sq[0] + p2_ff.sq[1];
      p3_ok     = (wsum != '0) && (wsum[W_BITS-1:TWOF] == '0);
      p3_in.w   = WN'(wsum[TWOF-1:0]);
      p3_in.mag = p2_ff.mag;
      p3_in.neg = p2_ff.neg;

      p4_in.w   = p3_ff.w;
      p4_in.e   = find_e(p3_ff.w);
      p4_in.mag = p3_ff.mag;
      p4_in.neg = p3_ff.neg;

      wn        = p4_ff.w << {p4_ff.e, 1'b0};
      b0_in.v   = wn;
      b0_in.res = '0;
      b0_in.x   = wn[WN-1] ? wn[WN-1:WN-QB] : wn[WN-2:WN-1-QB];
      b0_in.f   = '0;
      b0_in.e   = p4_ff.e;
      b0_in.n   = N_BITS'(TWOF + 2 * int'(p4_ff.e) - (WN - 2) - int'(wn[WN-1]));
      b0_in.mag = p4_ff.mag;
      b0_in.neg = p4_ff.neg;

      lq       = {b_ff[SQ_STEPS].n, {Q30{1'b0}}} - LQ_BITS'(b_ff[SQ_STEPS].f);
      c_in.hi  = lq[LQ_BITS-1:Q30];
      c_in.lo  = lq[Q30-1:0];
      c_in.s   = b_ff[SQ_STEPS].res[QB-1:0];
      c_in.neg = b_ff[SQ_STEPS].neg;
      for (int i = 0; i < 2; i++) begin
         nd = ND_BITS'(b_ff[SQ_STEPS].mag[i]) << (int'(b_ff[SQ_STEPS].e) + Q30);
         c_in.rem[i] = nd[2*QB-1:QB];
         c_in.low[i] = nd[QB-1:0];
      end

      m_in.mh  = MH_BITS'(c_ff.hi) * MH_BITS'(pgs_pkg::TWO_LN2_Q30);
      m_in.ml  = ML_BITS'(c_ff.lo) * ML_BITS'(pgs_pkg::TWO_LN2_Q30);
      m_in.s   = c_ff.s;
      m_in.rem = c_ff.rem;
      m_in.low = c_ff.low;
      m_in.neg = c_ff.neg;

      d0_in.s   = m_ff.s;
      d0_in.rem = m_ff.rem;
      d0_in.low = m_ff.low;
      d0_in.q   = '0;
      d0_in.tv  = VX'(V_BITS'(m_ff.mh) + V_BITS'(m_ff.ml[ML_BITS-1:Q30]));
      d0_in.tr  = '0;
      d0_in.neg = m_ff.neg;

      g_in.neg = d_ff[QB].neg;
      for (int i = 0; i < 2; i++) begin
         g_in.prod[i] = P_BITS'(d_ff[QB].q[i]) * P_BITS'(d_ff[QB].tr[T_STEPS-1:0]);
      end

      for (int i = 0; i < 2; i++) begin
         rs  = (P_BITS + 1)'(g_ff.prod[i]) + RND;
         r   = rs[P_BITS:RS-1+1];
         lim = g_ff.neg[i] ? pgs_pkg::OUT_NEG_MAX : pgs_pkg::OUT_POS_MAX;
         mg  = (r > R_BITS'(lim)) ? lim : r[OB:0];
         out_val_in[i] = g_ff.neg[i] ? OB'(-mg) : OB'(mg);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         p3_ff   <= p3_in;
         p4_ff   <= p4_in;
         b_ff[0] <= b0_in;
         for (int k = 0; k < SQ_STEPS; k++) begin
            b_ff[k+1] <= b_step(b_ff[k], k);
         end
         c_ff    <= c_in;
         m_ff    <= m_in;
         d_ff[0] <= d0_in;
         for (int k = 0; k < QB; k++) begin
            d_ff[k+1] <= d_step(d_ff[k], k);
         end
         g_ff       <= g_in;
         out_val_ff <= out_val_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff   <= 1'b0;
         p2_vld_ff   <= 1'b0;
         p3_vld_ff   <= 1'b0;
         p4_vld_ff   <= 1'b0;
         b_vld_ff    <= '0;
         c_vld_ff    <= 1'b0;
         m_vld_ff    <= 1'b0;
         d_vld_ff    <= '0;
         g_vld_ff    <= 1'b0;
         out_vld_ff  <= 1'b0;
         out_last_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff   <= req_valid;
         p2_vld_ff   <= p1_vld_ff;
         p3_vld_ff   <= p2_vld_ff && p3_ok;   // rejected pairs drop here
         p4_vld_ff   <= p3_vld_ff;
         b_vld_ff    <= {b_vld_ff[SQ_STEPS-1:0], p4_vld_ff};
         c_vld_ff    <= b_vld_ff[SQ_STEPS];
         m_vld_ff    <= c_vld_ff;
         d_vld_ff    <= {d_vld_ff[QB-1:0], m_vld_ff};
         g_vld_ff    <= d_vld_ff[QB];
         out_vld_ff  <= g_vld_ff;
         out_last_ff <= 1'b0;
      end else if (rsp_ready) begin
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_last_of_pair = out_last_ff;
   assign rsp_normal_value = out_last_ff ? out_val_ff[1] : out_val_ff[0];

   `PGS_ASSERT_NEXT(a_pair_second, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_pair, rsp_valid && rsp_last_of_pair)
   `PGS_ASSERT_NOW(a_w_nonzero, clock, reset, p3_vld_ff, p3_ff.w != '0)
   `PGS_ASSERT_NOW(a_log_norm, clock, reset, b_vld_ff[0], b_ff[0].x[QB-1])
   `PGS_ASSERT_NOW(a_root_range, clock, reset, b_vld_ff[SQ_STEPS], b_ff[SQ_STEPS].res[QB-1] && (b_ff[SQ_STEPS].res[WN-1:QB] == '0))
   `PGS_ASSERT_NOW(a_rem_below, clock, reset, d_vld_ff[QB], (d_ff[QB].rem[0] < d_ff[QB].s) && (d_ff[QB].rem[1] < d_ff[QB].s))
endmodule
`default_nettype wire

### sim/polar_gaussian_sampler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polar Gaussian sampler checker
// Watches both channels, predicts the deviate pair of each accepted, unrejected
// uniform pair and compares every output word against the oldest expectation.
// ----------------------------------------------------------------------------
module polar_gaussian_sampler_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic signed [15:0]  req_uniform_first,
   input  logic signed [15:0]  req_uniform_second,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic signed [15:0]  rsp_normal_value,
   input  logic                rsp_last_of_pair,
   output int                  fail_count,
   output int                  pending
);
   typedef struct packed {
      logic signed [15:0] value;
      logic               last;
   } deviate_type;

   deviate_type deviate_q[$];

   localparam logic [63:0] TWO_LN2 = 64'd1488522236;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] scale_deviate(logic signed [15:0] u, int e,
                                                 logic [63:0] s, logic [63:0] t);
      logic [63:0] mag, q, r;
      mag = u < 0 ? 64'(-32'(u)) : 64'(u);
      q = (mag << (e + 30)) / s;
      r = (q * t + (64'd1 << 32)) >> 33;
      if (u < 0) begin
         if (r > 64'd32768) r = 64'd32768;
         return 16'(64'd0 - r);
      end
      if (r > 64'd32767) r = 64'd32767;
      return 16'(r);
   endfunction

   task automatic predict_pair(logic signed [15:0] u1, logic signed [15:0] u2);
      logic [63:0] a1, a2, w, wn, s, x, f, lq, v, t;
      int e, p;
      deviate_type d;
      a1 = u1 < 0 ? 64'(-32'(u1)) : 64'(u1);
      a2 = u2 < 0 ? 64'(-32'(u2)) : 64'(u2);
      w = a1 * a1 + a2 * a2;
      if (w == 0 || w >= (64'd1 << 30)) return;
      wn = w;
      e = 0;
      while (wn < (64'd1 << 60)) begin
         wn = wn << 2;
         e++;
      end
      p = wn >= (64'd1 << 61) ? 61 : 60;
      s = int_sqrt(wn);
      x = wn >> (p - 30);
      f = '0;
      for (int i = 0; i < 30; i++) begin
         x = (x * x) >> 30;
         f = f << 1;
         if (x >= (64'd1 << 31)) begin
            f = f | 64'd1;
            x = x >> 1;
         end
      end
      lq = (64'(30 + 2 * e - p) << 30) - f;
      v = (lq >> 30) * TWO_LN2 + (((lq & ((64'd1 << 30) - 1)) * TWO_LN2) >> 30);
      t = int_sqrt(v);
      d.value = scale_deviate(u1, e, s, t);
      d.last = 1'b0;
      deviate_q.push_back(d);
      d.value = scale_deviate(u2, e, s, t);
      d.last = 1'b1;
      deviate_q.push_back(d);
   endtask

   task automatic report_mismatch(string what);
      $display("%0t: MISMATCH %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      deviate_type exp_word;
      if (!reset) begin
         if (req_valid && req_ready)
            predict_pair(req_uniform_first, req_uniform_second);
         if (rsp_valid && rsp_ready) begin
            if (deviate_q.size() == 0) begin
               report_mismatch($sformatf("unexpected word %0d", rsp_normal_value));
            end else begin
               exp_word = deviate_q.pop_front();
               if (rsp_normal_value !== exp_word.value)
                  report_mismatch($sformatf("normal_value got %0d exp %0d",
                                            rsp_normal_value, exp_word.value));
               if (rsp_last_of_pair !== exp_word.last)
                  report_mismatch($sformatf("last_of_pair got %0b exp %0b",
                                            rsp_last_of_pair, exp_word.last));
            end
         end
      end
      pending = deviate_q.size();
   end
endmodule

### sim/polar_gaussian_sampler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polar Gaussian sampler testbench
// Drives directed and random uniform pairs under several idle/stall phases;
// the checker predicts and compares the deviate words.
// ----------------------------------------------------------------------------
module polar_gaussian_sampler_tb;
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_uniform_first;
   logic signed [15:0] req_uniform_second;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_normal_value;
   logic               rsp_last_of_pair;
   int                 fail_count;
   int                 pending;
   int                 idle_pct;
   int                 stall_pct;

   polar_gaussian_sampler u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_uniform_first  (req_uniform_first),
      .req_uniform_second (req_uniform_second),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_normal_value   (rsp_normal_value),
      .rsp_last_of_pair   (rsp_last_of_pair)
   );

   polar_gaussian_sampler_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_uniform_first  (req_uniform_first),
      .req_uniform_second (req_uniform_second),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_normal_value   (rsp_normal_value),
      .rsp_last_of_pair   (rsp_last_of_pair),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_pair(logic signed [15:0] u1, logic signed [15:0] u2);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_uniform_first <= u1;
      req_uniform_second <= u2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_pair();
      logic signed [15:0] u1, u2;
      int r;
      r = $urandom_range(99);
      if (r < 70) begin
         // mostly inside the unit circle
         u1 = 16'($urandom_range(46340) - 23170);
         u2 = 16'($urandom_range(46340) - 23170);
      end else if (r < 80) begin
         // tiny radius, large deviates
         u1 = 16'($urandom_range(64) - 32);
         u2 = 16'($urandom_range(64) - 32);
      end else begin
         u1 = 16'($urandom);
         u2 = 16'($urandom);
      end
      send_pair(u1, u2);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_uniform_first = '0;
      req_uniform_second = '0;
      idle_pct = 0;
      stall_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair(16'sd0, 16'sd0);
      send_pair(16'sd1, 16'sd0);
      send_pair(16'sd0, -16'sd1);
      send_pair(16'sd1, 16'sd1);
      send_pair(-16'sd1, -16'sd1);
      send_pair(16'sh7fff, 16'sd0);
      send_pair(16'sd0, 16'sh7fff);
      send_pair(-16'sh7fff, 16'sd0);
      send_pair(16'sh8000, 16'sd0);
      send_pair(16'sd0, 16'sh8000);
      send_pair(16'sh8000, 16'sh8000);
      send_pair(16'sh7fff, 16'sh7fff);
      send_pair(16'sd23170, 16'sd23170);
      send_pair(16'sd23170, -16'sd23171);
      send_pair(16'sd16384, -16'sd16384);
      send_pair(-16'sd5, 16'sd3);
      send_pair(16'sh5555, -16'sh2aaa);
      send_pair(16'sd2, -16'sd32767);
      drain();
      repeat (100) @(posedge clock);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 67; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 67; end
            3: begin idle_pct = 26; stall_pct = 26; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         for (int n = 0; n < 130; n++) begin
            random_pair();
            if (n == 60) begin
               drain();
            end
         end
      end

      stall_pct = 0;
      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
